/* hdl/lge_pkg.sv */
// types and constants shared by the life generation engine
// no dependencies; used by lge_window and life_generation_engine
`timescale 1ns / 1ps
`default_nettype none

package lge_pkg;

  // command codes carried in the cmd field
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_WR_MOD,
    S_RD_PICK,
    S_CLEAR,
    S_FETCH,
    S_WAIT,
    S_CALC,
    S_WB,
    S_END,
    S_DONE
  } state_t;

  // control from the sequencer to the window unit
  typedef struct packed {
    logic load;       // shift a fresh row into the window
    logic rotate;     // evaluate one cell and rotate the rows
    logic clear_cnt;  // restart the live tally
  } win_ctrl_t;

  localparam int GEN_W   = 32;
  localparam int ALIVE_W = 12;

  localparam logic [ALIVE_W-1:0] ALIVE_MAX = 12'd4095;

  // b3/s23 neighbor counts
  localparam logic [3:0] BIRTH_N   = 4'd3;
  localparam logic [3:0] SURVIVE_N = 4'd2;

endpackage

`default_nettype wire

/* hdl/life_generation_engine.sv */
// life generation engine top level: command sequencer, counters, result register
// depends on lge_pkg, lge_row_mem and lge_window
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Command channel: cmd, col, row, cell_in with cmd_valid / cmd_stall. A word is
// taken when cmd_valid is high and cmd_stall is low. One command runs at a time;
// cmd_stall is high from acceptance until the result is loaded.
// Result channel: cell_out, generation_count, alive_count with res_valid /
// res_stall. Every command gives exactly one result word.
// Work from acceptance to the result register:
//   write or read inside the grid: a row read, then a row write or a bit pick;
//   outside the grid: no grid access; clear: one grid row written per cycle
//   step: the one-cell-per-cycle window unit plus one row write and one row
//   reload per row
// The grid is held as rows in one memory with two banks; a step reads the
// current bank and writes the other, then swaps them.
// Reset: a clearing pass writes every row of the current bank with cmd_stall
// high; counters start at zero.
// A stalled result holds; the next command may be accepted meanwhile and its
// result waits in the sequencer until the result register is free.

module life_generation_engine #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  output logic             cmd_stall,
  input  wire logic [1:0]  cmd,
  input  wire logic [5:0]  col,
  input  wire logic [4:0]  row,
  input  wire logic        cell_in,
  output logic             res_valid,
  input  wire logic        res_stall,
  output logic             cell_out,
  output logic [lge_pkg::GEN_W-1:0]   generation_count,
  output logic [lge_pkg::ALIVE_W-1:0] alive_count
);

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int CW    = $clog2(GRID_WIDTH);
  localparam int RW    = $clog2(GRID_HEIGHT);
  localparam int AW    = RW + 1;
  localparam int LW    = $clog2(CELLS + 1);

  localparam logic [CW-1:0] LAST_COL = CW'(GRID_WIDTH - 1);
  localparam logic [RW-1:0] LAST_ROW = RW'(GRID_HEIGHT - 1);

  lge_pkg::state_t    state;
  lge_pkg::state_t    state_next;
  lge_pkg::win_ctrl_t win_ctrl;
  lge_pkg::cmd_t      cmd_reg;

  logic                      cur;
  logic [RW-1:0]             row_idx;
  logic [RW-1:0]             rd_row;
  logic [CW-1:0]             col_cnt;
  logic [1:0]                fetch_cnt;
  logic                      load_pend;
  logic [CW-1:0]             col_reg;
  logic [RW-1:0]             row_reg;
  logic                      cell_reg;
  logic                      cell_rd;
  logic [lge_pkg::GEN_W-1:0] gen_cnt;
  logic [LW-1:0]             live_cnt;
  logic [LW-1:0]             step_total;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [GRID_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [GRID_WIDTH-1:0] mem_rdata;
  logic [GRID_WIDTH-1:0] step_row;

  logic cmd_accept;
  logic res_free;
  logic in_inside;
  logic old_bit;
  logic [lge_pkg::ALIVE_W-1:0] alive_sat;

  assign cmd_stall  = (state != lge_pkg::S_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign res_free   = !res_valid || !res_stall;
  assign in_inside  = (32'(col) < GRID_WIDTH) && (32'(row) < GRID_HEIGHT);
  assign old_bit    = mem_rdata[col_reg];
  assign alive_sat  = (32'(live_cnt) > 32'(lge_pkg::ALIVE_MAX)) ? lge_pkg::ALIVE_MAX
                                                               : lge_pkg::ALIVE_W'(live_cnt);

  // grid storage, two banks selected by the top address bit
  lge_row_mem #(
    .DW (GRID_WIDTH),
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // generation window
  lge_window #(
    .W  (GRID_WIDTH),
    .LW (LW)
  ) u_win (
    .clk        (clk),
    .ctrl       (win_ctrl),
    .row_in     (mem_rdata),
    .row_out    (step_row),
    .live_total (step_total)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lge_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state, memory and window control
  always_comb begin
    logic [GRID_WIDTH-1:0] wr_row;
    wr_row          = mem_rdata;
    wr_row[col_reg] = cell_reg;
    state_next      = state;
    mem_we          = 1'b0;
    mem_waddr       = {cur, row_idx};
    mem_wdata       = '0;
    mem_raddr       = {cur, rd_row};
    win_ctrl        = '0;
    win_ctrl.load   = load_pend;
    unique case (state)
      lge_pkg::S_INIT: begin
        mem_we = 1'b1;
        if (row_idx == LAST_ROW) begin
          state_next = lge_pkg::S_IDLE;
        end
      end
      lge_pkg::S_IDLE: begin
        mem_raddr = {cur, RW'(row)};
        if (cmd_accept) begin
          unique case (lge_pkg::cmd_t'(cmd))
            lge_pkg::CMD_WRITE: state_next = in_inside ? lge_pkg::S_WR_MOD : lge_pkg::S_DONE;
            lge_pkg::CMD_READ:  state_next = in_inside ? lge_pkg::S_RD_PICK : lge_pkg::S_DONE;
            lge_pkg::CMD_CLEAR: state_next = lge_pkg::S_CLEAR;
            lge_pkg::CMD_STEP:  state_next = lge_pkg::S_FETCH;
            default:            state_next = lge_pkg::S_DONE;
          endcase
        end
      end
      lge_pkg::S_WR_MOD: begin
        mem_we     = 1'b1;
        mem_waddr  = {cur, row_reg};
        mem_wdata  = wr_row;
        state_next = lge_pkg::S_DONE;
      end
      lge_pkg::S_RD_PICK: begin
        state_next = lge_pkg::S_DONE;
      end
      lge_pkg::S_CLEAR: begin
        mem_we = 1'b1;
        if (row_idx == LAST_ROW) begin
          state_next = lge_pkg::S_DONE;
        end
      end
      lge_pkg::S_FETCH: begin
        win_ctrl.clear_cnt = 1'b1;
        if (fetch_cnt == 2'd2) begin
          state_next = lge_pkg::S_WAIT;
        end
      end
      lge_pkg::S_WAIT: begin
        state_next = lge_pkg::S_CALC;
      end
      lge_pkg::S_CALC: begin
        win_ctrl.rotate = 1'b1;
        if (col_cnt == LAST_COL) begin
          state_next = lge_pkg::S_WB;
        end
      end
      lge_pkg::S_WB: begin
        mem_we     = 1'b1;
        mem_waddr  = {~cur, row_idx};
        mem_wdata  = step_row;
        state_next = (row_idx == LAST_ROW) ? lge_pkg::S_END : lge_pkg::S_WAIT;
      end
      lge_pkg::S_END: begin
        state_next = lge_pkg::S_DONE;
      end
      lge_pkg::S_DONE: begin
        if (res_free) begin
          state_next = lge_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lge_pkg::S_INIT;
      end
    endcase
  end

  // sequencer counters, grid counters and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= 1'b0;
      row_idx   <= '0;
      rd_row    <= LAST_ROW;
      col_cnt   <= '0;
      fetch_cnt <= '0;
      load_pend <= 1'b0;
      gen_cnt   <= '0;
      live_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      load_pend <= (state == lge_pkg::S_FETCH) || (state == lge_pkg::S_WB);
      // result valid: raised when a word is loaded, dropped when taken
      if (state == lge_pkg::S_DONE && res_free) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        lge_pkg::S_INIT, lge_pkg::S_CLEAR: begin
          row_idx <= (row_idx == LAST_ROW) ? '0 : row_idx + RW'(1);
          if (state == lge_pkg::S_CLEAR && row_idx == LAST_ROW) begin
            live_cnt <= '0;
            gen_cnt  <= '0;
          end
        end
        lge_pkg::S_IDLE: begin
          if (cmd_accept) begin
            row_idx   <= '0;
            rd_row    <= LAST_ROW;
            col_cnt   <= '0;
            fetch_cnt <= '0;
          end
        end
        lge_pkg::S_WR_MOD: begin
          if (old_bit && !cell_reg) begin
            live_cnt <= live_cnt - LW'(1);
          end else if (!old_bit && cell_reg) begin
            live_cnt <= live_cnt + LW'(1);
          end
        end
        lge_pkg::S_FETCH: begin
          fetch_cnt <= fetch_cnt + 2'd1;
          rd_row    <= (rd_row == LAST_ROW) ? '0 : rd_row + RW'(1);
        end
        lge_pkg::S_CALC: begin
          col_cnt <= (col_cnt == LAST_COL) ? '0 : col_cnt + CW'(1);
        end
        lge_pkg::S_WB: begin
          rd_row  <= (rd_row == LAST_ROW) ? '0 : rd_row + RW'(1);
          row_idx <= (row_idx == LAST_ROW) ? '0 : row_idx + RW'(1);
        end
        lge_pkg::S_END: begin
          cur      <= ~cur;
          live_cnt <= step_total;
          gen_cnt  <= gen_cnt + lge_pkg::GEN_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // command word capture and read data
  always_ff @(posedge clk) begin
    if (cmd_accept) begin
      cmd_reg  <= lge_pkg::cmd_t'(cmd);
      col_reg  <= CW'(col);
      row_reg  <= RW'(row);
      cell_reg <= cell_in;
      cell_rd  <= 1'b0;
    end else if (state == lge_pkg::S_RD_PICK && cmd_reg == lge_pkg::CMD_READ) begin
      cell_rd <= old_bit;
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == lge_pkg::S_DONE && res_free) begin
      cell_out         <= cell_rd;
      generation_count <= gen_cnt;
      alive_count      <= alive_sat;
    end
  end

  // a step never writes the bank it is reading
  assert property (@(posedge clk) disable iff (rst)
    (state == lge_pkg::S_WB) |-> (mem_we && (mem_waddr[AW-1] != cur)))
    else $error("step write-back targets the current bank");

  // clear leaves both counters at zero
  assert property (@(posedge clk) disable iff (rst)
    (state == lge_pkg::S_CLEAR && state_next == lge_pkg::S_DONE)
    |=> (gen_cnt == '0 && live_cnt == '0))
    else $error("counters not zero after clear");

  // live count never exceeds the grid size
  assert property (@(posedge clk) disable iff (rst)
    (32'(live_cnt) <= CELLS))
    else $error("live count beyond grid size");

  // a result word only comes out of the finishing state
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == lge_pkg::S_DONE))
    else $error("result raised outside the finishing state");

  // the bank swaps only at the end of a step
  assert property (@(posedge clk) disable iff (rst)
    (cur != $past(cur)) |-> ($past(state) == lge_pkg::S_END))
    else $error("bank select changed outside a step");

endmodule

`default_nettype wire

/* hdl/lge_row_mem.sv */
// grid row memory: one write port, one read port, registered read data
// no dependencies; instantiated by life_generation_engine
`timescale 1ns / 1ps
`default_nettype none

module lge_row_mem #(
  parameter int DW = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/lge_window.sv */
// three-row window: rotates rows past fixed taps, applies b3/s23 per cell
// depends on lge_pkg; instantiated by life_generation_engine
`timescale 1ns / 1ps
`default_nettype none

module lge_window #(
  parameter int W  = 64,
  parameter int LW = 12
) (
  input  wire logic             clk,
  input  wire lge_pkg::win_ctrl_t ctrl,
  input  wire logic [W-1:0]     row_in,
  output logic      [W-1:0]     row_out,
  output logic      [LW-1:0]    live_total
);

  logic [W-1:0] up;
  logic [W-1:0] mid;
  logic [W-1:0] dn;
  logic [3:0]   nbr;
  logic         alive;

  // neighbor taps: left at top bit, center at bit 0, right at bit 1
  assign nbr = 4'(up[W-1]) + 4'(up[0]) + 4'(up[1])
             + 4'(mid[W-1]) + 4'(mid[1])
             + 4'(dn[W-1]) + 4'(dn[0]) + 4'(dn[1]);

  assign alive = (nbr == lge_pkg::BIRTH_N) || (mid[0] && (nbr == lge_pkg::SURVIVE_N));

  // row window: shift in on load, rotate right on each evaluated cell
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      up  <= mid;
      mid <= dn;
      dn  <= row_in;
    end else if (ctrl.rotate) begin
      up  <= {up[0], up[W-1:1]};
      mid <= {mid[0], mid[W-1:1]};
      dn  <= {dn[0], dn[W-1:1]};
    end
  end

  // result row fills from the top, cell zero lands at bit 0
  always_ff @(posedge clk) begin
    if (ctrl.rotate) begin
      row_out <= {alive, row_out[W-1:1]};
    end
  end

  // live tally over one generation
  always_ff @(posedge clk) begin
    if (ctrl.clear_cnt) begin
      live_total <= '0;
    end else if (ctrl.rotate && alive) begin
      live_total <= live_total + LW'(1);
    end
  end

endmodule

`default_nettype wire

/* test/tb_life_generation_engine.sv */
// testbench for life_generation_engine: cell writes and reads, clears and b3/s23
// generation steps on the wrapped 64 x 32 grid, checked against a behavioral shadow grid
// depends on lge_pkg and the life_generation_engine rtl
`timescale 1ns / 1ps

module tb_life_generation_engine;

  localparam int COLS         = 64;
  localparam int ROWS         = 32;
  localparam int DRAIN_CYCLES = 2200;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_WORDS = 270;
  localparam int TAIL_WORDS   = 20;

  typedef struct {
    logic                        cell_bit;
    logic [lge_pkg::GEN_W-1:0]   gen;
    logic [lge_pkg::ALIVE_W-1:0] alive;
  } life_result_t;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  logic [1:0] cmd;
  logic [5:0] col;
  logic [4:0] row;
  logic cell_in;
  logic res_valid;
  logic res_stall;
  logic cell_out;
  logic [lge_pkg::GEN_W-1:0] generation_count;
  logic [lge_pkg::ALIVE_W-1:0] alive_count;

  // shadow of the block state
  bit shadow_grid [ROWS][COLS];
  logic [lge_pkg::GEN_W-1:0] shadow_gen;
  int unsigned shadow_alive;

  life_result_t pending_results[$];
  int mismatches;
  int words_sent;
  int results_seen;
  int op_tally [4];
  int peak_alive;
  int unsigned cycles;
  bit steady_tail;

  life_generation_engine #(
    .GRID_WIDTH (COLS),
    .GRID_HEIGHT(ROWS)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd_stall       (cmd_stall),
    .cmd             (cmd),
    .col             (col),
    .row             (row),
    .cell_in         (cell_in),
    .res_valid       (res_valid),
    .res_stall       (res_stall),
    .cell_out        (cell_out),
    .generation_count(generation_count),
    .alive_count     (alive_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one b3/s23 generation over the wrapped shadow grid
  function automatic void advance_shadow_generation();
    bit fresh [ROWS][COLS];
    int r, c, dr, dc, n;
    int unsigned total;
    total = 0;
    for (r = 0; r < ROWS; r++) begin
      for (c = 0; c < COLS; c++) begin
        n = 0;
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) begin
              n += shadow_grid[(r + dr + ROWS) % ROWS][(c + dc + COLS) % COLS];
            end
          end
        end
        if (shadow_grid[r][c]) begin
          fresh[r][c] = (n == lge_pkg::SURVIVE_N) || (n == lge_pkg::BIRTH_N);
        end else begin
          fresh[r][c] = (n == lge_pkg::BIRTH_N);
        end
        total += fresh[r][c];
      end
    end
    shadow_grid  = fresh;
    shadow_alive = total;
    shadow_gen   = shadow_gen + 1'b1;
  endfunction

  // apply one accepted command to the shadow and give the result it should produce
  function automatic life_result_t predict_life_result(lge_pkg::cmd_t op, int c, int r, bit v);
    life_result_t res;
    bit on_grid;
    on_grid      = (c < COLS) && (r < ROWS);
    res.cell_bit = 1'b0;
    case (op)
      lge_pkg::CMD_WRITE: begin
        if (on_grid) begin
          if (shadow_grid[r][c] && !v) shadow_alive--;
          else if (!shadow_grid[r][c] && v) shadow_alive++;
          shadow_grid[r][c] = v;
        end
      end
      lge_pkg::CMD_STEP: begin
        advance_shadow_generation();
      end
      lge_pkg::CMD_CLEAR: begin
        foreach (shadow_grid[i, j]) shadow_grid[i][j] = 1'b0;
        shadow_alive = 0;
        shadow_gen   = '0;
      end
      default: begin
        if (on_grid) res.cell_bit = shadow_grid[r][c];
      end
    endcase
    res.gen   = shadow_gen;
    res.alive = (shadow_alive > lge_pkg::ALIVE_MAX) ? lge_pkg::ALIVE_MAX
                                                    : shadow_alive[lge_pkg::ALIVE_W-1:0];
    if (shadow_alive > peak_alive) peak_alive = shadow_alive;
    return res;
  endfunction

  // send one command word, with an occasional idle burst ahead of it
  task automatic send_word(lge_pkg::cmd_t op, int c, int r, bit v);
    if (!steady_tail && $urandom_range(0, 9) == 0) begin
      cmd_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= op;
    col       <= c[5:0];
    row       <= r[4:0];
    cell_in   <= v;
    // settled values at the falling edge decide the next rising edge
    @(negedge clk);
    while (cmd_stall) @(negedge clk);
    @(posedge clk);
    pending_results.push_back(predict_life_result(op, c, r, v));
    op_tally[op]++;
    words_sent++;
  endtask

  // result side stall in random bursts
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && !steady_tail && $urandom_range(0, 7) == 0) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        res_stall <= 1'b0;
      end
    end
  end

  // compare each taken result word with the oldest expectation
  initial begin
    life_result_t want;
    forever begin
      @(negedge clk);
      if (!rst && res_valid && !res_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with no expectation pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (cell_out !== want.cell_bit) begin
            $error("cell_out expected %0d actual %0d", want.cell_bit, cell_out);
            mismatches++;
          end
          if (generation_count !== want.gen) begin
            $error("generation_count expected %0d actual %0d", want.gen, generation_count);
            mismatches++;
          end
          if (alive_count !== want.alive) begin
            $error("alive_count expected %0d actual %0d", want.alive, alive_count);
            mismatches++;
          end
        end
      end
    end
  end

  // cycle limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $error("timeout after %0d cycles, %0d results pending", cycles, pending_results.size());
    $display("Mismatches found");
    $finish;
  end

  // single cell writes and reads, mostly at the grid extremes; live count only rises
  task automatic test_cell_access();
    send_word(lge_pkg::CMD_READ, 0, 0, 1'b1);
    send_word(lge_pkg::CMD_WRITE, 0, 0, 1'b1);
    send_word(lge_pkg::CMD_WRITE, COLS - 1, 0, 1'b1);
    send_word(lge_pkg::CMD_WRITE, 0, ROWS - 1, 1'b1);
    send_word(lge_pkg::CMD_WRITE, COLS - 1, ROWS - 1, 1'b1);
    send_word(lge_pkg::CMD_WRITE, COLS - 1, ROWS - 1, 1'b1);
    send_word(lge_pkg::CMD_READ, COLS - 1, ROWS - 1, 1'b0);
    send_word(lge_pkg::CMD_WRITE, 5, 5, 1'b0);
  endtask

  // neighbors wrap on every edge: corner block, then a blinker across the side
  task automatic test_wrapped_neighbors();
    send_word(lge_pkg::CMD_STEP, COLS - 1, ROWS - 1, 1'b1);
    send_word(lge_pkg::CMD_READ, 0, ROWS - 1, 1'b1);
    send_word(lge_pkg::CMD_WRITE, 0, 0, 1'b0);
    send_word(lge_pkg::CMD_STEP, 0, 0, 1'b0);
    send_word(lge_pkg::CMD_READ, 0, 0, 1'b0);
    send_word(lge_pkg::CMD_CLEAR, 0, 0, 1'b0);
    send_word(lge_pkg::CMD_WRITE, COLS - 1, 10, 1'b1);
    send_word(lge_pkg::CMD_WRITE, 0, 10, 1'b1);
    send_word(lge_pkg::CMD_WRITE, 1, 10, 1'b1);
    send_word(lge_pkg::CMD_STEP, 21, 10, 1'b0);
    send_word(lge_pkg::CMD_READ, 0, 9, 1'b0);
    send_word(lge_pkg::CMD_READ, COLS - 1, 10, 1'b1);
    send_word(lge_pkg::CMD_STEP, 42, 21, 1'b1);
  endtask

  // clear with every unused field set, then a read of a former live cell
  task automatic test_clear();
    send_word(lge_pkg::CMD_CLEAR, COLS - 1, ROWS - 1, 1'b1);
    send_word(lge_pkg::CMD_READ, 1, 10, 1'b1);
  endtask

  // seeded patches that evolve over a few generations, mixed with stray words
  task automatic test_random_life(int target);
    int base_c, base_r, span;
    while (words_sent < target) begin
      if ($urandom_range(0, 4) == 0) begin
        send_word(lge_pkg::CMD_CLEAR, $urandom_range(0, COLS - 1),
                  $urandom_range(0, ROWS - 1), $urandom_range(0, 1));
      end
      base_c = $urandom_range(0, COLS - 1);
      base_r = $urandom_range(0, ROWS - 1);
      span   = $urandom_range(3, 8);
      repeat ($urandom_range(4, 20)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_word(lge_pkg::cmd_t'($urandom_range(0, 3)), $urandom_range(0, COLS - 1),
                    $urandom_range(0, ROWS - 1), $urandom_range(0, 1));
        end else begin
          send_word(lge_pkg::CMD_WRITE, (base_c + $urandom_range(0, span - 1)) % COLS,
                    (base_r + $urandom_range(0, span - 1)) % ROWS, $urandom_range(0, 3) != 0);
        end
      end
      repeat ($urandom_range(1, 3)) begin
        send_word(lge_pkg::CMD_STEP, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                  $urandom_range(0, 1));
        repeat ($urandom_range(0, 3)) begin
          send_word(lge_pkg::CMD_READ, (base_c + $urandom_range(0, span + 1)) % COLS,
                    (base_r + $urandom_range(0, span + 1)) % ROWS, $urandom_range(0, 1));
        end
      end
    end
  endtask

  // back-to-back words with no idling on either side
  task automatic test_steady_tail();
    int k;
    steady_tail = 1'b1;
    for (k = 0; k < TAIL_WORDS; k++) begin
      if (k % 8 == 7) begin
        send_word(lge_pkg::CMD_STEP, $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                  $urandom_range(0, 1));
      end else begin
        send_word(($urandom_range(0, 1) != 0) ? lge_pkg::CMD_WRITE : lge_pkg::CMD_READ,
                  $urandom_range(0, COLS - 1), $urandom_range(0, ROWS - 1),
                  $urandom_range(0, 1));
      end
    end
  endtask

  // reset, tests in turn, drain, verdict
  initial begin
    rst          <= 1'b1;
    cmd_valid    <= 1'b0;
    cmd          <= lge_pkg::CMD_WRITE;
    col          <= '0;
    row          <= '0;
    cell_in      <= 1'b0;
    shadow_gen   = '0;
    shadow_alive = 0;
    foreach (shadow_grid[i, j]) shadow_grid[i][j] = 1'b0;
    mismatches   = 0;
    words_sent   = 0;
    results_seen = 0;
    peak_alive   = 0;
    steady_tail  = 1'b0;
    foreach (op_tally[i]) op_tally[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_cell_access();
    test_wrapped_neighbors();
    test_clear();
    test_random_life(RANDOM_WORDS);
    test_steady_tail();

    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words: %0d writes, %0d steps, %0d clears, %0d reads; %0d results checked",
             words_sent, op_tally[lge_pkg::CMD_WRITE], op_tally[lge_pkg::CMD_STEP],
             op_tally[lge_pkg::CMD_CLEAR], op_tally[lge_pkg::CMD_READ], results_seen);
    $display("peak live cells %0d, last generation count %0d", peak_alive, shadow_gen);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
